[sv/mmbr_pkg.sv]
package mmbr_pkg;

    localparam int MAX_ROWS_DEF  = 64;
    localparam int MAX_INNER_DEF = 64;
    localparam int MAX_COLS_DEF  = 64;

    localparam int IDX_W   = 6;
    localparam int VALUE_W = 32;
    localparam int SUM_W   = 64;
    localparam int CFG_W   = 7;
    localparam int REG_W   = 3;

    localparam logic [1:0] OP_LOAD_A = 2'd0;
    localparam logic [1:0] OP_LOAD_B = 2'd1;
    localparam logic [1:0] OP_STEP   = 2'd2;

    localparam logic [REG_W-1:0] REG_FIRST_ROW = 3'd0;
    localparam logic [REG_W-1:0] REG_LAST_ROW  = 3'd1;
    localparam logic [REG_W-1:0] REG_FIRST_COL = 3'd2;
    localparam logic [REG_W-1:0] REG_LAST_COL  = 3'd3;
    localparam logic [REG_W-1:0] REG_INNER_LEN = 3'd4;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // partial sum travelling down the cell chain
    typedef struct packed {
        logic                    vld;
        logic signed [SUM_W-1:0] sum;
    } link_t;

    function automatic int addr_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] acc,
        input logic signed [SUM_W-1:0] p
    );
        logic signed [SUM_W-1:0] s;
        s = acc + p;
        if ((acc[SUM_W-1] == p[SUM_W-1]) && (s[SUM_W-1] != acc[SUM_W-1])) begin
            return acc[SUM_W-1] ? SUM_MIN : SUM_MAX;
        end
        return s;
    endfunction

endpackage

[sv/mmbr_ram.sv]
module mmbr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [mmbr_pkg::addr_width(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [mmbr_pkg::addr_width(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/mmbr_cell.sv]
module mmbr_cell #(
    parameter int MAX_ROWS = mmbr_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = mmbr_pkg::MAX_COLS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      a_we,
    input  logic [mmbr_pkg::addr_width(MAX_ROWS)-1:0] a_waddr,
    input  logic                                      b_we,
    input  logic [mmbr_pkg::addr_width(MAX_COLS)-1:0] b_waddr,
    input  logic [mmbr_pkg::VALUE_W-1:0]              wdata,
    input  logic [mmbr_pkg::addr_width(MAX_ROWS)-1:0] a_raddr,
    input  logic [mmbr_pkg::addr_width(MAX_COLS)-1:0] b_raddr,
    input  logic                                      active,
    input  mmbr_pkg::link_t                           link_in,
    output mmbr_pkg::link_t                           link_out
);
    import mmbr_pkg::*;

    logic [VALUE_W-1:0]        a_rdata;
    logic [VALUE_W-1:0]        b_rdata;
    logic signed [VALUE_W-1:0] a_s;
    logic signed [VALUE_W-1:0] b_s;
    logic signed [SUM_W-1:0]   prod_reg;
    link_t                     link_reg;

    // one column of A and one row of B live in this cell
    mmbr_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ROWS)) u_ram_a (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    mmbr_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_COLS)) u_ram_b (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    assign a_s = $signed(a_rdata);
    assign b_s = $signed(b_rdata);

    always_ff @(posedge aclk) begin
        prod_reg <= a_s * b_s;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg.vld <= 1'b0;
        end else begin
            link_reg.vld <= link_in.vld;
            if (link_in.vld) begin
                link_reg.sum <= active ? sat_add(link_in.sum, prod_reg) : link_in.sum;
            end
        end
    end

    assign link_out = link_reg;

endmodule

[sv/matrix_multiply_block_range_top.sv]
// Channel  | Ports                                        | Dir
// input    | s_valid s_ready s_op s_row s_col s_value      | in
// result   | m_valid m_ready m_out_row m_out_col m_sum m_last | out
// config   | cfg_we cfg_index cfg_wdata                   | in
//
// A step beat's result is registered at the output once the partial sum has
// walked the chain of MAX_INNER MAC cells, one cell per cycle, after a
// registered read address, a RAM read and a product stage.
// One step in flight at a time; loads are taken while a result waits.
// Synchronous active-low reset; the element stores are not cleared.
module matrix_multiply_block_range_top #(
    parameter int MAX_ROWS  = mmbr_pkg::MAX_ROWS_DEF,
    parameter int MAX_INNER = mmbr_pkg::MAX_INNER_DEF,
    parameter int MAX_COLS  = mmbr_pkg::MAX_COLS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_op,
    input  logic [mmbr_pkg::IDX_W-1:0]          s_row,
    input  logic [mmbr_pkg::IDX_W-1:0]          s_col,
    input  logic signed [mmbr_pkg::VALUE_W-1:0] s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [mmbr_pkg::IDX_W-1:0]          m_out_row,
    output logic [mmbr_pkg::IDX_W-1:0]          m_out_col,
    output logic signed [mmbr_pkg::SUM_W-1:0]   m_sum,
    output logic                                m_last,
    input  logic                                cfg_we,
    input  logic [mmbr_pkg::REG_W-1:0]          cfg_index,
    input  logic [mmbr_pkg::CFG_W-1:0]          cfg_wdata
);
    import mmbr_pkg::*;

    localparam int ROW_AW = addr_width(MAX_ROWS);
    localparam int COL_AW = addr_width(MAX_COLS);

    state_t state_reg, state_next;

    logic [IDX_W-1:0] first_row_reg, last_row_reg, first_col_reg, last_col_reg;
    logic [CFG_W-1:0] inner_len_reg;
    logic [IDX_W-1:0] cur_row_reg, cur_col_reg;
    logic [ROW_AW-1:0] rd_row_reg;
    logic [COL_AW-1:0] rd_col_reg;
    logic [2:0]        launch_reg;
    logic [IDX_W-1:0]  res_row_reg, res_col_reg;
    logic              res_last_reg, res_zero_reg;
    logic              m_valid_reg;
    logic signed [SUM_W-1:0] m_sum_reg;

    logic accept, step_acc, load_a_ok, load_b_ok, row_end, col_end, done;
    logic [MAX_INNER-1:0] a_we, b_we, active;
    link_t link [MAX_INNER+1];

    assign accept    = s_valid && s_ready;
    assign step_acc  = accept && (s_op == OP_STEP);
    assign load_a_ok = accept && (s_op == OP_LOAD_A)
                       && (32'(s_row) < MAX_ROWS) && (32'(s_col) < MAX_INNER);
    assign load_b_ok = accept && (s_op == OP_LOAD_B)
                       && (32'(s_row) < MAX_INNER) && (32'(s_col) < MAX_COLS);
    assign row_end   = cur_row_reg >= last_row_reg;
    assign col_end   = cur_col_reg >= last_col_reg;
    assign done      = link[MAX_INNER].vld;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = (s_op != OP_STEP) || !m_valid_reg || m_ready;
                if (step_acc) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // configuration and result cursor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_row_reg <= '0;
            last_row_reg  <= '1;
            first_col_reg <= '0;
            last_col_reg  <= '1;
            inner_len_reg <= CFG_W'(64);
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_FIRST_ROW: begin
                    first_row_reg <= cfg_wdata[IDX_W-1:0];
                    cur_row_reg   <= cfg_wdata[IDX_W-1:0];
                    cur_col_reg   <= first_col_reg;
                end
                REG_LAST_ROW: begin
                    last_row_reg <= cfg_wdata[IDX_W-1:0];
                    cur_row_reg  <= first_row_reg;
                    cur_col_reg  <= first_col_reg;
                end
                REG_FIRST_COL: begin
                    first_col_reg <= cfg_wdata[IDX_W-1:0];
                    cur_row_reg   <= first_row_reg;
                    cur_col_reg   <= cfg_wdata[IDX_W-1:0];
                end
                REG_LAST_COL: begin
                    last_col_reg <= cfg_wdata[IDX_W-1:0];
                    cur_row_reg  <= first_row_reg;
                    cur_col_reg  <= first_col_reg;
                end
                REG_INNER_LEN: begin
                    inner_len_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end else if (step_acc) begin
            if (col_end) begin
                cur_col_reg <= first_col_reg;
                cur_row_reg <= row_end ? first_row_reg : cur_row_reg + 1'b1;
            end else begin
                cur_col_reg <= cur_col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step_acc) begin
            rd_row_reg   <= ROW_AW'(cur_row_reg);
            rd_col_reg   <= COL_AW'(cur_col_reg);
            res_row_reg  <= cur_row_reg;
            res_col_reg  <= cur_col_reg;
            res_last_reg <= row_end && col_end;
            res_zero_reg <= (32'(cur_row_reg) >= MAX_ROWS) || (32'(cur_col_reg) >= MAX_COLS);
        end
        if (done) begin
            m_sum_reg <= res_zero_reg ? '0 : link[MAX_INNER].sum;
        end
    end

    // RAM read, then product, then the sum enters the first cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            launch_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            launch_reg <= {launch_reg[1:0], step_acc};
            if (done) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign link[0] = '{vld: launch_reg[2], sum: '0};

    for (genvar k = 0; k < MAX_INNER; k++) begin : g_cell
        assign a_we[k]   = load_a_ok && (32'(s_col) == k);
        assign b_we[k]   = load_b_ok && (32'(s_row) == k);
        assign active[k] = 32'(inner_len_reg) > k;

        mmbr_cell #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .a_we     (a_we[k]),
            .a_waddr  (ROW_AW'(s_row)),
            .b_we     (b_we[k]),
            .b_waddr  (COL_AW'(s_col)),
            .wdata    (s_value),
            .a_raddr  (rd_row_reg),
            .b_raddr  (rd_col_reg),
            .active   (active[k]),
            .link_in  (link[k]),
            .link_out (link[k+1])
        );
    end

    assign m_valid   = m_valid_reg;
    assign m_out_row = res_row_reg;
    assign m_out_col = res_col_reg;
    assign m_sum     = m_sum_reg;
    assign m_last    = res_last_reg;

endmodule

[sv/mmbr_checker.sv]
module mmbr_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic [1:0]                          s_op,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [mmbr_pkg::IDX_W-1:0]          m_out_row,
    input logic [mmbr_pkg::IDX_W-1:0]          m_out_col,
    input logic signed [mmbr_pkg::SUM_W-1:0]   m_sum,
    input logic                                m_last
);
    import mmbr_pkg::*;

    // a step beat occupies the chain
    a_step_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_op == OP_STEP) |=> !s_ready)
        else $error("input taken while a step is in the chain");

    // a step is only taken once the previous result is gone
    a_step_frees_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_op == OP_STEP) |=> !m_valid)
        else $error("step taken over a pending result");

    // a result only appears at the end of a step
    a_result_from_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result without a step in progress");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sum) && $stable(m_last)
            && $stable(m_out_row) && $stable(m_out_col))
        else $error("stalled result beat changed");

endmodule

bind matrix_multiply_block_range_top mmbr_checker u_mmbr_checker (.*);
